FILE: design/vt4_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// vt4_pkg
// Shared widths, types and reset constants for the 4x4 vertex transform.
// ---------------------------------------------------------------------------
package vt4_pkg;

	// Matrix and vertex geometry.
	localparam int NUM_ROWS = 4;
	localparam int NUM_COMP = 4;
	localparam int IDX_W    = $clog2(NUM_ROWS);

	// Fixed-point widths: Q4.12 coefficients, Q8.8 components, Q16.8 results.
	localparam int COEF_W     = 16;
	localparam int ROW_W      = COEF_W * NUM_COMP;
	localparam int VTX_W      = 16;
	localparam int OUT_W      = 24;
	localparam int PROD_W     = COEF_W + VTX_W;
	localparam int PAIR_W     = PROD_W + 1;
	localparam int SUM_W      = PROD_W + 2;
	localparam int FRAC_SHIFT = 12;

	// Coefficient value 1.0 in Q4.12.
	localparam logic [COEF_W-1:0] COEF_ONE = COEF_W'(1) << FRAC_SHIFT;

	// Half of one result LSB, added before the floor shift.
	localparam logic signed [SUM_W-1:0] ROUND_HALF = SUM_W'(1) << (FRAC_SHIFT - 1);

	// Saturation bounds of the 24-bit result, sign-extended to the sum width.
	localparam logic signed [SUM_W-1:0] OUT_MAX = SUM_W'((64'sd1 <<< (OUT_W - 1)) - 64'sd1);
	localparam logic signed [SUM_W-1:0] OUT_MIN = SUM_W'(-(64'sd1 <<< (OUT_W - 1)));

	typedef logic [NUM_ROWS-1:0][ROW_W-1:0]  matrix_t;
	typedef logic [NUM_COMP-1:0][VTX_W-1:0]  vertex_t;
	typedef logic [OUT_W-1:0]                result_t;

	// Reset value of row r: identity, 1.0 on the diagonal.
	function automatic logic [ROW_W-1:0] row_reset(input int r);
		logic [ROW_W-1:0] v;
		v = ROW_W'(COEF_ONE) << (COEF_W * r);
		return v;
	endfunction

endpackage
`default_nettype wire

FILE: design/vt4_cfg_regs.sv
`default_nettype none
// ---------------------------------------------------------------------------
// vt4_cfg_regs
// Matrix row registers, written through the plain configuration port.
// ---------------------------------------------------------------------------
module vt4_cfg_regs (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    cfg_we,
	input  wire logic [vt4_pkg::IDX_W-1:0] cfg_index,
	input  wire logic [vt4_pkg::ROW_W-1:0] cfg_data,
	output vt4_pkg::matrix_t             rows
);
	import vt4_pkg::*;

	matrix_t row_q;

	// Rows come out of reset as the identity matrix; a write replaces one row.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < NUM_ROWS; r++) begin
				row_q[r] <= row_reset(r);
			end
		end else if (cfg_we) begin
			row_q[cfg_index] <= cfg_data;
		end
	end

	assign rows = row_q;

endmodule
`default_nettype wire

FILE: design/vt4_row_dot.sv
`default_nettype none
// ---------------------------------------------------------------------------
// vt4_row_dot
// One matrix row times the vertex: multiply, pair add, then final add with
// rounding and saturation, one register stage each.
// ---------------------------------------------------------------------------
module vt4_row_dot (
	input  wire logic                      clk,
	input  wire logic [vt4_pkg::ROW_W-1:0] row,
	input  wire vt4_pkg::vertex_t          vtx_s1,
	output vt4_pkg::result_t               res_s4
);
	import vt4_pkg::*;

	logic signed [PROD_W-1:0] prod_s2 [NUM_COMP];
	logic signed [PAIR_W-1:0] pair_s3 [2];
	logic signed [SUM_W-1:0]  sum_c;
	logic signed [SUM_W-1:0]  rnd_c;
	logic signed [SUM_W-1:0]  sat_c;

	// Stage 2: four independent 16x16 signed products.
	always_ff @(posedge clk) begin
		for (int k = 0; k < NUM_COMP; k++) begin
			prod_s2[k] <= $signed(row[COEF_W*k +: COEF_W]) * $signed(vtx_s1[k]);
		end
	end

	// Stage 3: add the products in pairs.
	always_ff @(posedge clk) begin
		pair_s3[0] <= PAIR_W'(prod_s2[0]) + PAIR_W'(prod_s2[1]);
		pair_s3[1] <= PAIR_W'(prod_s2[2]) + PAIR_W'(prod_s2[3]);
	end

	// Final sum with half an LSB added, then an arithmetic shift floors it.
	always_comb begin
		sum_c = SUM_W'(pair_s3[0]) + SUM_W'(pair_s3[1]) + ROUND_HALF;
		rnd_c = sum_c >>> FRAC_SHIFT;
		if (rnd_c > OUT_MAX) begin
			sat_c = OUT_MAX;
		end else if (rnd_c < OUT_MIN) begin
			sat_c = OUT_MIN;
		end else begin
			sat_c = rnd_c;
		end
	end

	// Stage 4: registered result word.
	always_ff @(posedge clk) begin
		res_s4 <= sat_c[OUT_W-1:0];
	end

endmodule
`default_nettype wire

FILE: design/vertex_transform_4x4_unit.sv
`default_nettype none
// ---------------------------------------------------------------------------
// vertex_transform_4x4_unit
// Fixed-point 4x4 matrix times homogeneous vertex, fully pipelined.
//
//   Channel   Handshake             Payload
//   -------   -------------------   ------------------------------------
//   input     start (busy low)      x_in, y_in, z_in, w_in  (Q8.8)
//   result    done, one cycle       x_out, y_out, z_out, w_out (Q16.8, 24b)
//   config    cfg_we, no wait       cfg_index, cfg_data (row, 4 x Q4.12)
//
// One word is accepted every cycle; busy stays low. An accepted word passes
// the input register, multiply, pair add and final add with rounding before
// its result appears. The sixteen multipliers set the cycle depth.
// Reset clears the valid pipeline and loads the identity matrix. The
// receiver cannot stall, so the pipeline never holds.
// ---------------------------------------------------------------------------
module vertex_transform_4x4_unit (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      start,
	output logic                           busy,
	input  wire logic signed [15:0]        x_in,
	input  wire logic signed [15:0]        y_in,
	input  wire logic signed [15:0]        z_in,
	input  wire logic signed [15:0]        w_in,
	input  wire logic                      cfg_we,
	input  wire logic [vt4_pkg::IDX_W-1:0] cfg_index,
	input  wire logic [vt4_pkg::ROW_W-1:0] cfg_data,
	output logic                           done,
	output logic signed [23:0]             x_out,
	output logic signed [23:0]             y_out,
	output logic signed [23:0]             z_out,
	output logic signed [23:0]             w_out
);
	import vt4_pkg::*;

	matrix_t rows;
	vertex_t vtx_s1;
	logic    vld_s1;
	logic    vld_s2;
	logic    vld_s3;
	logic    vld_s4;
	result_t res_s4 [NUM_ROWS];
	logic    accept;

	// The pipeline takes a word every cycle.
	assign busy   = 1'b0;
	assign accept = start && !busy;

	vt4_cfg_regs u_cfg_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.rows      (rows)
	);

	// Stage 1: capture the vertex word.
	always_ff @(posedge clk) begin
		if (accept) begin
			vtx_s1 <= {w_in, z_in, y_in, x_in};
		end
	end

	// Valid bits travel alongside the data stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			vld_s1 <= accept;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	// One dot-product pipeline per matrix row.
	for (genvar r = 0; r < NUM_ROWS; r++) begin : g_row
		vt4_row_dot u_row_dot (
			.clk    (clk),
			.row    (rows[r]),
			.vtx_s1 (vtx_s1),
			.res_s4 (res_s4[r])
		);
	end

	assign done  = vld_s4;
	assign x_out = res_s4[0];
	assign y_out = res_s4[1];
	assign z_out = res_s4[2];
	assign w_out = res_s4[3];

`ifndef SYNTHESIS
	// Every accepted word yields a result after the input, multiply, pair-add and result registers.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##4 done)
		else $error("accepted word did not produce a result after four cycles");

	// No result appears without a matching accepted word.
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(accept, 4))
		else $error("result strobe without a matching accepted word");

	// Rounded sums stay within 23 bits, so the saturation never engages.
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (x_out[23] == x_out[22]) && (y_out[23] == y_out[22]) &&
			(z_out[23] == z_out[22]) && (w_out[23] == w_out[22]))
		else $error("result outside the reachable range");

	// A zero vertex maps to a zero result in the matching slot.
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && x_in == 16'sd0 && y_in == 16'sd0 && z_in == 16'sd0 &&
			w_in == 16'sd0) |-> ##4 (x_out == 24'sd0 && y_out == 24'sd0 &&
			z_out == 24'sd0 && w_out == 24'sd0))
		else $error("zero vertex produced a nonzero result");
`endif

endmodule
`default_nettype wire

FILE: sim/testbench.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench
// Self-checking bench for vertex_transform_4x4_unit. A local predictor
// multiplies each accepted vertex word by the current matrix, rounding half
// up to Q16.8. The result words that the block strobes out on done are
// compared field by field with the oldest prediction. Matrices are loaded
// only while the pipeline is empty. Directed words cover the field
// extremes, the largest products and the rounding ties. Random streams
// with random gaps run under several random, extreme and identity matrices.
// ---------------------------------------------------------------------------
module testbench;
	import vt4_pkg::*;

	// Register indexes of the configuration port.
	localparam logic [IDX_W-1:0] REG_ROW_0 = IDX_W'(0);
	localparam logic [IDX_W-1:0] REG_ROW_1 = IDX_W'(1);
	localparam logic [IDX_W-1:0] REG_ROW_2 = IDX_W'(2);
	localparam logic [IDX_W-1:0] REG_ROW_3 = IDX_W'(3);

	localparam longint RES_MAX   = 64'sd8388607;
	localparam longint RES_MIN   = -64'sd8388608;
	localparam int     IDLE_LIMIT = 1000;
	localparam int     PIPE_DEPTH = 4;
	localparam int     MAX_GAP    = 12;
	localparam int     RAND_PHASES = 8;
	localparam int     PHASE_WORDS = 200;

	typedef logic [NUM_ROWS-1:0][OUT_W-1:0] xform_t;

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic signed [15:0] x_in;
	logic signed [15:0] y_in;
	logic signed [15:0] z_in;
	logic signed [15:0] w_in;
	logic               cfg_we;
	logic [IDX_W-1:0]   cfg_index;
	logic [ROW_W-1:0]   cfg_data;
	logic               done;
	logic signed [23:0] x_out;
	logic signed [23:0] y_out;
	logic signed [23:0] z_out;
	logic signed [23:0] w_out;

	matrix_t cur_matrix;
	xform_t  expected_q[$];
	int      mismatches;
	int      words_sent;
	int      results_checked;
	int      matrix_loads;
	int      idle_style;
	int      idle_cycles;

	vertex_transform_4x4_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.x_in      (x_in),
		.y_in      (y_in),
		.z_in      (z_in),
		.w_in      (w_in),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.done      (done),
		.x_out     (x_out),
		.y_out     (y_out),
		.z_out     (z_out),
		.w_out     (w_out)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Matrix times vertex, rounded half toward plus infinity, then clamped.
	function automatic xform_t transform_vertex(input matrix_t m, input vertex_t v);
		xform_t res;
		longint acc;
		longint rounded;
		for (int r = 0; r < NUM_ROWS; r++) begin
			acc = 0;
			for (int k = 0; k < NUM_COMP; k++) begin
				acc += longint'($signed(m[r][COEF_W*k +: COEF_W])) * longint'($signed(v[k]));
			end
			rounded = (acc + (longint'(1) << (FRAC_SHIFT - 1))) >>> FRAC_SHIFT;
			if (rounded > RES_MAX)
				rounded = RES_MAX;
			if (rounded < RES_MIN)
				rounded = RES_MIN;
			res[r] = OUT_W'(rounded);
		end
		return res;
	endfunction

	function automatic vertex_t make_vertex(input logic [15:0] x, input logic [15:0] y,
			input logic [15:0] z, input logic [15:0] w);
		vertex_t v;
		v[0] = x;
		v[1] = y;
		v[2] = z;
		v[3] = w;
		return v;
	endfunction

	// Mostly full-range values, with the extremes and small magnitudes mixed in.
	function automatic logic [15:0] rand_value();
		logic [15:0] v;
		case ($urandom_range(0, 7))
			0: begin
				case ($urandom_range(0, 4))
					0: v = 16'h8000;
					1: v = 16'h7fff;
					2: v = 16'h0000;
					3: v = 16'hffff;
					default: v = 16'h0001;
				endcase
			end
			1: v = 16'($signed($urandom_range(0, 8191)) - 4096);
			default: v = 16'($urandom);
		endcase
		return v;
	endfunction

	function automatic vertex_t rand_vertex();
		return make_vertex(rand_value(), rand_value(), rand_value(), rand_value());
	endfunction

	function automatic matrix_t rand_matrix(input bit extremes_only);
		matrix_t m;
		for (int r = 0; r < NUM_ROWS; r++) begin
			for (int k = 0; k < NUM_COMP; k++) begin
				if (extremes_only)
					m[r][COEF_W*k +: COEF_W] = $urandom_range(0, 1) ? 16'h8000 : 16'h7fff;
				else
					m[r][COEF_W*k +: COEF_W] = rand_value();
			end
		end
		return m;
	endfunction

	// Gap before the next word, by the current idling style.
	function automatic int next_gap();
		case (idle_style)
			0: return 0;
			1: return $urandom_range(0, MAX_GAP);
			default: return ($urandom_range(0, 5) == 0) ? $urandom_range(1, MAX_GAP) : 0;
		endcase
	endfunction

	// Offer one vertex word and hold it until it is accepted.
	task automatic send_vertex(input vertex_t v, input int gap);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		x_in  <= v[0];
		y_in  <= v[1];
		z_in  <= v[2];
		w_in  <= v[3];
		do @(posedge clk); while (busy);
		expected_q.push_back(transform_vertex(cur_matrix, v));
		words_sent++;
	endtask

	// Stop offering words and wait until every predicted result is out.
	task automatic drain_pipeline();
		start <= 1'b0;
		while (expected_q.size() != 0) @(posedge clk);
		repeat (PIPE_DEPTH + 2) @(posedge clk);
	endtask

	// Write all four rows; only called with the pipeline empty.
	task automatic load_matrix(input matrix_t m);
		cfg_we    <= 1'b1;
		cfg_index <= REG_ROW_0;
		cfg_data  <= m[0];
		@(posedge clk);
		cfg_index <= REG_ROW_1;
		cfg_data  <= m[1];
		@(posedge clk);
		cfg_index <= REG_ROW_2;
		cfg_data  <= m[2];
		@(posedge clk);
		cfg_index <= REG_ROW_3;
		cfg_data  <= m[3];
		@(posedge clk);
		cfg_we     <= 1'b0;
		cur_matrix = m;
		matrix_loads++;
	endtask

	// Identity matrix from reset, with extreme and patterned vertices.
	task automatic test_reset_identity();
		idle_style = 1;
		send_vertex(make_vertex(16'h0000, 16'h0000, 16'h0000, 16'h0000), next_gap());
		send_vertex(make_vertex(16'h7fff, 16'h8000, 16'h7fff, 16'h8000), next_gap());
		send_vertex(make_vertex(16'h8000, 16'h7fff, 16'h8000, 16'h7fff), next_gap());
		send_vertex(make_vertex(16'hffff, 16'h0001, 16'hffff, 16'h0001), next_gap());
		send_vertex(make_vertex(16'h5555, 16'haaaa, 16'h5555, 16'haaaa), next_gap());
		send_vertex(make_vertex(16'h0100, 16'h0100, 16'h0100, 16'h0100), next_gap());
	endtask

	// Largest products of both signs, reaching the widest sums.
	task automatic test_extreme_products();
		matrix_t m;
		drain_pipeline();
		m = {NUM_ROWS{{NUM_COMP{16'h8000}}}};
		load_matrix(m);
		send_vertex(make_vertex(16'h8000, 16'h8000, 16'h8000, 16'h8000), 0);
		send_vertex(make_vertex(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff), 0);
		drain_pipeline();
		m = {NUM_ROWS{{NUM_COMP{16'h7fff}}}};
		load_matrix(m);
		send_vertex(make_vertex(16'h8000, 16'h8000, 16'h8000, 16'h8000), next_gap());
		send_vertex(make_vertex(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff), next_gap());
	endtask

	// Ties and near-ties of the rounding, on both sides of zero.
	task automatic test_rounding();
		matrix_t m;
		drain_pipeline();
		m[0] = 64'h0000_0000_0000_0001;
		m[1] = 64'h0000_0000_0000_ffff;
		m[2] = 64'h0001_0001_0001_0001;
		m[3] = 64'h0000_0000_0000_0800;
		load_matrix(m);
		send_vertex(make_vertex(16'h0800, 16'h0000, 16'h0000, 16'h0000), 0);
		send_vertex(make_vertex(16'hf800, 16'h0000, 16'h0000, 16'h0000), 0);
		send_vertex(make_vertex(16'hf7ff, 16'h0000, 16'h0000, 16'h0000), next_gap());
		send_vertex(make_vertex(16'h07ff, 16'h0000, 16'h0000, 16'h0000), next_gap());
		send_vertex(make_vertex(16'h0001, 16'h0200, 16'h0200, 16'h0200), 0);
		send_vertex(make_vertex(16'hffff, 16'hfe00, 16'hfe00, 16'hfe01), 0);
	endtask

	// Random streams under random, extreme and identity matrices.
	task automatic test_random_stream();
		matrix_t m;
		for (int p = 0; p < RAND_PHASES; p++) begin
			drain_pipeline();
			if (p == RAND_PHASES - 1) begin
				for (int r = 0; r < NUM_ROWS; r++)
					m[r] = row_reset(r);
			end else begin
				m = rand_matrix(p == 3);
			end
			load_matrix(m);
			for (int i = 0; i < PHASE_WORDS; i++) begin
				if (i % 40 == 0)
					idle_style = $urandom_range(0, 2);
				// Hold off in mid-phase until the pipeline has emptied.
				if (i == PHASE_WORDS / 2)
					drain_pipeline();
				send_vertex(rand_vertex(), next_gap());
			end
		end
	endtask

	// Compare each result word with the oldest prediction.
	always @(posedge clk) begin
		xform_t exp_res;
		xform_t got;
		string  names[NUM_ROWS];
		names = '{"x_out", "y_out", "z_out", "w_out"};
		if (arst_n && done) begin
			got = {w_out, z_out, y_out, x_out};
			if (expected_q.size() == 0) begin
				$error("result word with no prediction pending");
				mismatches++;
			end else begin
				exp_res = expected_q.pop_front();
				results_checked++;
				for (int r = 0; r < NUM_ROWS; r++) begin
					if (got[r] !== exp_res[r]) begin
						$error("%s mismatch: expected %0d, got %0d", names[r],
							$signed(exp_res[r]), $signed(got[r]));
						mismatches++;
					end
				end
			end
		end
	end

	// End the run if no word moves on either side for too long.
	always @(posedge clk) begin
		if ((start && !busy) || done)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("timeout: no word moved for %0d cycles", IDLE_LIMIT);
			$display("TB_ERROR");
			$finish;
		end
	end

	initial begin
		arst_n          = 1'b0;
		start           = 1'b0;
		x_in            = '0;
		y_in            = '0;
		z_in            = '0;
		w_in            = '0;
		cfg_we          = 1'b0;
		cfg_index       = '0;
		cfg_data        = '0;
		idle_cycles     = 0;
		mismatches      = 0;
		words_sent      = 0;
		results_checked = 0;
		matrix_loads    = 0;
		idle_style      = 0;
		for (int r = 0; r < NUM_ROWS; r++)
			cur_matrix[r] = row_reset(r);
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_identity();
		test_extreme_products();
		test_rounding();
		test_random_stream();

		drain_pipeline();
		if (expected_q.size() != 0) begin
			$error("%0d predicted results never arrived", expected_q.size());
			mismatches++;
		end
		$display("Sent %0d vertex words under %0d matrix loads plus the reset identity.",
			words_sent, matrix_loads);
		$display("Checked %0d result words, %0d mismatches.", results_checked, mismatches);
		if (mismatches == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

FILE: vertex_transform_4x4_unit.f
design/vt4_pkg.sv
design/vt4_cfg_regs.sv
design/vt4_row_dot.sv
design/vertex_transform_4x4_unit.sv
sim/testbench.sv
